// File: src/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg
// Types and constants shared by the request lifecycle tracker.
// ----------------------------------------------------------------------------
package rlt_pkg;

   localparam int unsigned TIME_W  = 64;
   localparam int unsigned TAG_W   = 32;
   localparam int unsigned LIMIT_W = 32;
   localparam int unsigned CSR_INDEX_W = 8;

   localparam logic [LIMIT_W-1:0] COOLDOWN_RESET = 32'd60000000;
   localparam logic [LIMIT_W-1:0] EXPIRY_RESET   = 32'd90000000;

   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPIRY   = 8'd1;

   typedef enum logic [1:0] {
      KIND_ENQUEUE = 2'd0,
      KIND_TAKE    = 2'd1,
      KIND_EXPIRE  = 2'd2,
      KIND_FINISH  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PENDING = 2'd1,
      PH_READY   = 2'd2,
      PH_ERROR   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_EXPIRED = 2'd1,
      ERR_FAILED  = 2'd2,
      ERR_CALLER  = 2'd3
   } error_type;

   typedef enum logic [2:0] {
      RSN_NONE     = 3'd0,
      RSN_MAINT    = 3'd1,
      RSN_OFFLINE  = 3'd2,
      RSN_CLOCK    = 3'd3,
      RSN_BUSY     = 3'd4,
      RSN_COOLDOWN = 3'd5
   } reason_type;

   typedef struct packed {
      kind_type                kind;
      logic signed [TIME_W-1:0] now_us;
      logic                    link_online;
      logic                    clock_ok;
      logic                    in_maintenance;
      logic [TAG_W-1:0]        finish_tag;
      logic                    has_result;
      logic                    error_supplied;
   } item_type;

   typedef struct packed {
      phase_type                phase;
      logic                     ever_requested;
      logic                     awaiting_take;
      logic                     job_running;
      logic signed [TIME_W-1:0] request_time;
      logic [TAG_W-1:0]         generation;
      error_type                stored_error;
   } state_type;

   typedef struct packed {
      logic             accepted;
      reason_type       reject_reason;
      logic [TAG_W-1:0] grant_tag;
      phase_type        phase_now;
      error_type        error_code;
   } result_type;

endpackage

// File: src/request_lifecycle_tracker.sv
// ----------------------------------------------------------------------------
// request_lifecycle_tracker
// Tracks one outstanding request through idle, pending, ready and error.
// ----------------------------------------------------------------------------
// One operation is taken per cycle while the result side does not stall,
// and each gives exactly one result. An operation is held in an input
// register, evaluated combinationally against the tracker state and lands
// in the result register, which presents the result until it transfers.
// A stalled result holds the operation in the input register and stalls
// the request side. The state updates as the operation moves into the
// result register, so the next operation always sees it.
// Configuration writes are taken in every cycle; write them only while no
// operation is in flight.
module request_lifecycle_tracker (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_kind,
   input  logic signed [rlt_pkg::TIME_W-1:0]  req_now_us,
   input  logic                               req_link_online,
   input  logic                               req_clock_ok,
   input  logic                               req_in_maintenance,
   input  logic [rlt_pkg::TAG_W-1:0]          req_finish_tag,
   input  logic                               req_has_result,
   input  logic                               req_error_supplied,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_accepted,
   output logic [2:0]                         rsp_reject_reason,
   output logic [rlt_pkg::TAG_W-1:0]          rsp_grant_tag,
   output logic [1:0]                         rsp_phase_now,
   output logic [1:0]                         rsp_error_code,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rlt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rlt_pkg::LIMIT_W-1:0]        csr_data
);
   import rlt_pkg::*;

   logic                 item_valid_ff;
   logic                 item_valid_in;
   item_type             item_ff;
   state_type            state_ff;
   state_type            state_next;
   result_type           result_next;
   result_type           result_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [LIMIT_W-1:0]   cooldown_ff;
   logic [LIMIT_W-1:0]   expiry_ff;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign item_valid_in = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   rlt_step u_step (
      .item        (item_ff),
      .state       (state_ff),
      .cooldown_us (cooldown_ff),
      .expiry_us   (expiry_ff),
      .state_next  (state_next),
      .result      (result_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cooldown_ff   <= COOLDOWN_RESET;
         expiry_ff     <= EXPIRY_RESET;
         state_ff      <= '{phase: PH_IDLE, stored_error: ERR_NONE, default: '0};
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_COOLDOWN) begin
               cooldown_ff <= csr_data;
            end else if (csr_index == CSR_EXPIRY) begin
               expiry_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.kind           <= kind_type'(req_kind);
         item_ff.now_us         <= req_now_us;
         item_ff.link_online    <= req_link_online;
         item_ff.clock_ok       <= req_clock_ok;
         item_ff.in_maintenance <= req_in_maintenance;
         item_ff.finish_tag     <= req_finish_tag;
         item_ff.has_result     <= req_has_result;
         item_ff.error_supplied <= req_error_supplied;
      end
      if (advance) begin
         result_ff <= result_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = result_ff.accepted;
   assign rsp_reject_reason = result_ff.reject_reason;
   assign rsp_grant_tag     = result_ff.grant_tag;
   assign rsp_phase_now     = result_ff.phase_now;
   assign rsp_error_code    = result_ff.error_code;

   a_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.accepted |-> result_ff.phase_now == PH_PENDING)
      else $error("accepted result without pending phase");

   a_reject_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (result_ff.reject_reason != RSN_NONE) |-> !result_ff.accepted)
      else $error("rejected result marked accepted");

   a_error_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.stored_error != ERR_NONE |-> state_ff.phase == PH_ERROR)
      else $error("stored error outside error phase");

   a_running_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff.job_running |-> state_ff.phase == PH_PENDING && !state_ff.awaiting_take)
      else $error("running job outside pending phase");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a transfer");

endmodule

// File: src/rlt_step.sv
// ----------------------------------------------------------------------------
// rlt_step
// Evaluates one operation against the tracker state: next state and result.
// ----------------------------------------------------------------------------
module rlt_step (
   input  rlt_pkg::item_type                 item,
   input  rlt_pkg::state_type                state,
   input  logic [rlt_pkg::LIMIT_W-1:0]       cooldown_us,
   input  logic [rlt_pkg::LIMIT_W-1:0]       expiry_us,
   output rlt_pkg::state_type                state_next,
   output rlt_pkg::result_type               result
);
   import rlt_pkg::*;

   logic              time_back;
   logic [TIME_W-1:0] age;
   logic              in_cooldown;
   logic              aged_out;
   logic              can_take;

   assign time_back   = item.now_us < state.request_time;
   assign age         = TIME_W'(item.now_us) - TIME_W'(state.request_time);
   assign in_cooldown = time_back || (age < {{(TIME_W-LIMIT_W){1'b0}}, cooldown_us});
   assign aged_out    = time_back || (age > {{(TIME_W-LIMIT_W){1'b0}}, expiry_us});
   assign can_take    = (state.phase == PH_PENDING) && state.awaiting_take
                        && !state.job_running;

   always_comb begin
      state_next = state;
      result.accepted      = 1'b0;
      result.reject_reason = RSN_NONE;
      result.grant_tag     = '0;

      unique case (item.kind)
         KIND_ENQUEUE: begin
            priority if (item.in_maintenance) begin
               result.reject_reason = RSN_MAINT;
            end else if (!item.link_online) begin
               result.reject_reason = RSN_OFFLINE;
            end else if (!item.clock_ok) begin
               result.reject_reason = RSN_CLOCK;
            end else if (state.phase == PH_PENDING) begin
               result.reject_reason = RSN_BUSY;
            end else if (state.ever_requested && in_cooldown) begin
               result.reject_reason = RSN_COOLDOWN;
            end else begin
               result.accepted           = 1'b1;
               state_next.ever_requested = 1'b1;
               state_next.awaiting_take  = 1'b1;
               state_next.job_running    = 1'b0;
               state_next.phase          = PH_PENDING;
               state_next.request_time   = item.now_us;
               state_next.generation     = state.generation + 1'b1;
               state_next.stored_error   = ERR_NONE;
            end
         end
         KIND_TAKE: begin
            if (can_take) begin
               state_next.awaiting_take = 1'b0;
               if (aged_out) begin
                  state_next.phase        = PH_ERROR;
                  state_next.stored_error = ERR_EXPIRED;
               end else begin
                  state_next.job_running = 1'b1;
                  result.accepted        = 1'b1;
                  result.grant_tag       = state.generation;
               end
            end
         end
         KIND_EXPIRE: begin
            if (can_take && aged_out) begin
               state_next.awaiting_take = 1'b0;
               state_next.phase         = PH_ERROR;
               state_next.stored_error  = ERR_EXPIRED;
            end
         end
         KIND_FINISH: begin
            if ((state.phase == PH_PENDING) && state.job_running
                && (state.generation == item.finish_tag)) begin
               state_next.job_running = 1'b0;
               if (item.has_result) begin
                  state_next.phase        = PH_READY;
                  state_next.stored_error = ERR_NONE;
               end else begin
                  state_next.phase        = PH_ERROR;
                  state_next.stored_error = item.error_supplied ? ERR_CALLER : ERR_FAILED;
               end
            end
         end
         default: begin
            state_next = state;
         end
      endcase

      result.phase_now  = state_next.phase;
      result.error_code = state_next.stored_error;
   end

endmodule

// File: verif/lifecycle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifecycle_checker
// Watches the request, result and register channels of the request lifecycle
// tracker. Every request transfer is run through a local model of the
// tracker state and limits, and every result transfer is compared field by
// field with the oldest predicted outcome. Mismatches are counted for the
// testbench top, which also gets the current tag, request time and number
// of outcomes still in flight to steer its stimulus.
// ----------------------------------------------------------------------------
module lifecycle_checker (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic signed [rlt_pkg::TIME_W-1:0]   req_now_us,
   input  logic                                req_link_online,
   input  logic                                req_clock_ok,
   input  logic                                req_in_maintenance,
   input  logic [rlt_pkg::TAG_W-1:0]           req_finish_tag,
   input  logic                                req_has_result,
   input  logic                                req_error_supplied,

   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_accepted,
   input  logic [2:0]                          rsp_reject_reason,
   input  logic [rlt_pkg::TAG_W-1:0]           rsp_grant_tag,
   input  logic [1:0]                          rsp_phase_now,
   input  logic [1:0]                          rsp_error_code,

   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [rlt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rlt_pkg::LIMIT_W-1:0]         csr_data,

   output int                                  fault_count,
   output int                                  open_count,
   output int                                  result_count,
   output int                                  accept_count,
   output int                                  refusal_count,
   output logic [rlt_pkg::TAG_W-1:0]           tag_hint,
   output logic signed [rlt_pkg::TIME_W-1:0]   time_hint
);
   import rlt_pkg::*;

   state_type          trk;
   logic [LIMIT_W-1:0] cool_lim;
   logic [LIMIT_W-1:0] exp_lim;
   result_type         outcome_q[$];

   initial begin
      fault_count   = 0;
      result_count  = 0;
      accept_count  = 0;
      refusal_count = 0;
   end

   task automatic report_fault(input string what, input logic [63:0] got,
                               input logic [63:0] want);
      $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
      fault_count++;
   endtask

   // Request older than `since`, or more than `window` after it.
   function automatic logic overdue(input logic signed [63:0] now,
                                    input logic signed [63:0] since,
                                    input logic [LIMIT_W-1:0] window);
      logic [63:0] age;
      age = now - since;
      return (now < since) || (age > {32'd0, window});
   endfunction

   function automatic result_type step_tracker(input item_type op);
      result_type         r;
      logic signed [63:0] now;
      logic signed [63:0] since;
      logic [63:0]        age;
      r     = '0;
      now   = op.now_us;
      since = trk.request_time;
      age   = now - since;
      case (op.kind)
         KIND_ENQUEUE: begin
            if (op.in_maintenance)
               r.reject_reason = RSN_MAINT;
            else if (!op.link_online)
               r.reject_reason = RSN_OFFLINE;
            else if (!op.clock_ok)
               r.reject_reason = RSN_CLOCK;
            else if (trk.phase == PH_PENDING)
               r.reject_reason = RSN_BUSY;
            else if (trk.ever_requested && ((now < since) || (age < {32'd0, cool_lim})))
               r.reject_reason = RSN_COOLDOWN;
            if (r.reject_reason == RSN_NONE) begin
               r.accepted         = 1'b1;
               trk.ever_requested = 1'b1;
               trk.awaiting_take  = 1'b1;
               trk.job_running    = 1'b0;
               trk.phase          = PH_PENDING;
               trk.request_time   = now;
               trk.generation     = trk.generation + 1'b1;
               trk.stored_error   = ERR_NONE;
            end
         end
         KIND_TAKE: begin
            if (trk.phase == PH_PENDING && trk.awaiting_take && !trk.job_running) begin
               trk.awaiting_take = 1'b0;
               if (overdue(now, since, exp_lim)) begin
                  trk.phase        = PH_ERROR;
                  trk.stored_error = ERR_EXPIRED;
               end else begin
                  trk.job_running = 1'b1;
                  r.accepted      = 1'b1;
                  r.grant_tag     = trk.generation;
               end
            end
         end
         KIND_EXPIRE: begin
            if (trk.phase == PH_PENDING && trk.awaiting_take && !trk.job_running &&
                overdue(now, since, exp_lim)) begin
               trk.awaiting_take = 1'b0;
               trk.phase         = PH_ERROR;
               trk.stored_error  = ERR_EXPIRED;
            end
         end
         KIND_FINISH: begin
            if (trk.phase == PH_PENDING && trk.job_running &&
                trk.generation == op.finish_tag) begin
               trk.job_running = 1'b0;
               if (op.has_result) begin
                  trk.phase        = PH_READY;
                  trk.stored_error = ERR_NONE;
               end else begin
                  trk.phase        = PH_ERROR;
                  trk.stored_error = op.error_supplied ? ERR_CALLER : ERR_FAILED;
               end
            end
         end
         default: ;
      endcase
      r.phase_now  = trk.phase;
      r.error_code = trk.stored_error;
      return r;
   endfunction

   always @(posedge clock) begin
      item_type   op;
      result_type want;
      if (reset) begin
         trk      = '0;
         cool_lim = COOLDOWN_RESET;
         exp_lim  = EXPIRY_RESET;
         outcome_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_COOLDOWN)
               cool_lim = csr_data;
            else if (csr_index == CSR_EXPIRY)
               exp_lim = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               report_fault("unexpected result, phase", 64'(rsp_phase_now), 64'd0);
            end else begin
               want = outcome_q.pop_front();
               result_count++;
               if (want.accepted)
                  accept_count++;
               if (want.reject_reason != RSN_NONE)
                  refusal_count++;
               if (rsp_accepted !== want.accepted)
                  report_fault("accepted", 64'(rsp_accepted), 64'(want.accepted));
               if (rsp_reject_reason !== want.reject_reason)
                  report_fault("reject_reason", 64'(rsp_reject_reason),
                               64'(want.reject_reason));
               if (rsp_grant_tag !== want.grant_tag)
                  report_fault("grant_tag", 64'(rsp_grant_tag), 64'(want.grant_tag));
               if (rsp_phase_now !== want.phase_now)
                  report_fault("phase_now", 64'(rsp_phase_now), 64'(want.phase_now));
               if (rsp_error_code !== want.error_code)
                  report_fault("error_code", 64'(rsp_error_code), 64'(want.error_code));
            end
         end
         if (req_valid && !req_stall) begin
            op.kind           = kind_type'(req_kind);
            op.now_us         = req_now_us;
            op.link_online    = req_link_online;
            op.clock_ok       = req_clock_ok;
            op.in_maintenance = req_in_maintenance;
            op.finish_tag     = req_finish_tag;
            op.has_result     = req_has_result;
            op.error_supplied = req_error_supplied;
            outcome_q.push_back(step_tracker(op));
         end
      end
      open_count <= outcome_q.size();
      tag_hint   <= trk.generation;
      time_hint  <= trk.request_time;
   end

endmodule

// File: verif/tb_request_lifecycle_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_request_lifecycle_tracker
// Drives the request lifecycle tracker with a directed pass over refusal
// reasons, grants, expiry, backwards time and finish outcomes, then with
// random request lifecycles and noise under several limit settings, the
// extremes among them. Both channels idle at random. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_request_lifecycle_tracker;
   import rlt_pkg::*;

   localparam int     CLK_PERIOD   = 10;
   localparam int     RESET_CYCLES = 12;
   localparam int     IDLE_PCT     = 6;
   localparam int     DRAIN_CYCLES = 4;
   localparam longint LIMIT_NS     = 2_000_000;
   localparam longint T_MIN        = 64'sh8000_0000_0000_0000;
   localparam longint T_MAX        = 64'sh7fff_ffff_ffff_ffff;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRAY = 8'hff;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_kind;
   logic signed [TIME_W-1:0]  req_now_us;
   logic                      req_link_online;
   logic                      req_clock_ok;
   logic                      req_in_maintenance;
   logic [TAG_W-1:0]          req_finish_tag;
   logic                      req_has_result;
   logic                      req_error_supplied;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_accepted;
   logic [2:0]                rsp_reject_reason;
   logic [TAG_W-1:0]          rsp_grant_tag;
   logic [1:0]                rsp_phase_now;
   logic [1:0]                rsp_error_code;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [LIMIT_W-1:0]        csr_data;

   int                        fault_count;
   int                        open_count;
   int                        result_count;
   int                        accept_count;
   int                        refusal_count;
   logic [TAG_W-1:0]          tag_hint;
   logic signed [TIME_W-1:0]  time_hint;

   logic                      calm = 1'b0;
   logic [LIMIT_W-1:0]        cool_cfg;
   logic [LIMIT_W-1:0]        exp_cfg;
   int                        setting_count;

   request_lifecycle_tracker dut (.*);
   lifecycle_checker chk (.*);

   always begin
      clock = 1'b0;
      #(CLK_PERIOD / 2);
      clock = 1'b1;
      #(CLK_PERIOD / 2);
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   initial begin
      #(LIMIT_NS);
      $display("Timeout: transfers stopped before the run completed");
      $display("TEST FAILED");
      $finish;
   end

   function automatic longint jitter();
      return longint'($urandom_range(4)) - 2;
   endfunction

   function automatic bit coin();
      return 1'($urandom_range(1));
   endfunction

   task automatic send_op(input kind_type k, input longint now, input bit online,
                          input bit clk_ok, input bit maint, input logic [TAG_W-1:0] tag,
                          input bit res, input bit sup);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= k;
      req_now_us         <= now;
      req_link_online    <= online;
      req_clock_ok       <= clk_ok;
      req_in_maintenance <= maint;
      req_finish_tag     <= tag;
      req_has_result     <= res;
      req_error_supplied <= sup;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic enqueue_at(input longint now);
      send_op(KIND_ENQUEUE, now, 1'b1, 1'b1, 1'b0, $urandom, coin(), coin());
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_limits(input logic [LIMIT_W-1:0] cool,
                                 input logic [LIMIT_W-1:0] expiry, input bit stray);
      write_csr(CSR_COOLDOWN, cool);
      write_csr(CSR_EXPIRY, expiry);
      if (stray)
         write_csr(CSR_STRAY, $urandom);
      csr_valid <= 1'b0;
      cool_cfg = cool;
      exp_cfg  = expiry;
      setting_count++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int n_items);
      int               done;
      int               pick;
      longint           t_enq;
      longint           t_take;
      longint           t_any;
      logic [TAG_W-1:0] tag;
      done = 0;
      while (done < n_items) begin
         if ($urandom_range(99) < 70) begin
            t_enq = time_hint + longint'(cool_cfg) + jitter();
            if ($urandom_range(9) == 0)
               send_op(KIND_ENQUEUE, t_enq, coin(), coin(), coin(), $urandom, coin(),
                       coin());
            else
               enqueue_at(t_enq);
            done++;
            if ($urandom_range(99) < 30) begin
               send_op(KIND_EXPIRE, t_enq + longint'(exp_cfg) + jitter(), 1'b1, 1'b1, 1'b0,
                       $urandom, coin(), coin());
               done++;
            end
            pick = $urandom_range(19);
            if (pick == 0)
               t_take = t_enq - 1;
            else if (pick < 10)
               t_take = t_enq + longint'($urandom_range(0, exp_cfg));
            else
               t_take = t_enq + longint'(exp_cfg) + jitter();
            send_op(KIND_TAKE, t_take, 1'b1, 1'b1, 1'b0, $urandom, coin(), coin());
            done++;
            if ($urandom_range(99) < 85) begin
               tag = ($urandom_range(99) < 85) ? tag_hint : TAG_W'($urandom);
               send_op(KIND_FINISH, t_take + longint'($urandom_range(1000)), 1'b1, 1'b1,
                       1'b0, tag, coin(), coin());
               done++;
            end
         end else begin
            if ($urandom_range(3) == 0)
               t_any = {$urandom, $urandom};
            else
               t_any = time_hint + 2 * longint'($urandom_range(0, cool_cfg))
                       - longint'(cool_cfg) + jitter();
            tag = coin() ? tag_hint : TAG_W'($urandom);
            send_op(kind_type'($urandom_range(3)), t_any, coin(), coin(), coin(), tag,
                    coin(), coin());
            done++;
         end
      end
   endtask

   initial begin
      longint t;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_kind           <= KIND_ENQUEUE;
      req_now_us         <= '0;
      req_link_online    <= 1'b0;
      req_clock_ok       <= 1'b0;
      req_in_maintenance <= 1'b0;
      req_finish_tag     <= '0;
      req_has_result     <= 1'b0;
      req_error_supplied <= 1'b0;
      csr_valid          <= 1'b0;
      csr_index          <= CSR_COOLDOWN;
      csr_data           <= '0;
      cool_cfg      = COOLDOWN_RESET;
      exp_cfg       = EXPIRY_RESET;
      setting_count = 1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // operations on an idle tracker do nothing
      send_op(KIND_TAKE, T_MIN, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
      send_op(KIND_EXPIRE, T_MIN, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
      send_op(KIND_FINISH, T_MIN, 1'b1, 1'b1, 1'b0, '0, 1'b1, 1'b0);
      // refusal priority: maintenance, offline, clock
      send_op(KIND_ENQUEUE, T_MAX, 1'b0, 1'b0, 1'b1, '1, 1'b1, 1'b1);
      send_op(KIND_ENQUEUE, T_MAX, 1'b0, 1'b0, 1'b0, '1, 1'b1, 1'b1);
      send_op(KIND_ENQUEUE, T_MAX, 1'b1, 1'b0, 1'b0, '1, 1'b1, 1'b1);
      enqueue_at(T_MIN);
      enqueue_at(T_MIN + 5);
      // age exactly at the expiry limit still counts as fresh
      t = T_MIN + longint'(EXPIRY_RESET);
      send_op(KIND_EXPIRE, t, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
      send_op(KIND_TAKE, t, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
      send_op(KIND_TAKE, t, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
      send_op(KIND_EXPIRE, T_MAX, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
      send_op(KIND_FINISH, t, 1'b1, 1'b1, 1'b0, tag_hint + 1'b1, 1'b1, 1'b0);
      send_op(KIND_FINISH, t, 1'b1, 1'b1, 1'b0, tag_hint, 1'b1, 1'b0);
      t = T_MIN + longint'(COOLDOWN_RESET);
      enqueue_at(t - 1);
      enqueue_at(t);
      // time running backwards
      send_op(KIND_TAKE, t - 1, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
      enqueue_at(t - 1);
      t = t + longint'(COOLDOWN_RESET);
      enqueue_at(t);
      send_op(KIND_EXPIRE, T_MAX, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
      t = t + longint'(COOLDOWN_RESET);
      enqueue_at(t);
      send_op(KIND_TAKE, t + longint'(EXPIRY_RESET) + 1, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
      t = t + longint'(COOLDOWN_RESET);
      enqueue_at(t);
      send_op(KIND_TAKE, t, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
      send_op(KIND_FINISH, t, 1'b1, 1'b1, 1'b0, tag_hint, 1'b0, 1'b0);
      t = t + longint'(COOLDOWN_RESET);
      enqueue_at(t);
      send_op(KIND_TAKE, t, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
      send_op(KIND_FINISH, t, 1'b1, 1'b1, 1'b0, tag_hint, 1'b0, 1'b1);
      settle();

      program_limits('0, '0, 1'b1);
      run_phase(110);
      settle();
      program_limits('1, '1, 1'b0);
      run_phase(80);
      settle();
      calm <= 1'b1;
      program_limits($urandom_range(1000), $urandom_range(1500), 1'b0);
      run_phase(130);
      settle();
      calm <= 1'b0;
      program_limits($urandom, $urandom, 1'b1);
      run_phase(110);
      settle();
      program_limits($urandom_range(200), $urandom_range(300), 1'b0);
      run_phase(120);
      settle();
      program_limits(COOLDOWN_RESET, EXPIRY_RESET, 1'b0);
      run_phase(100);
      settle();

      $display("Checked %0d results across %0d limit settings", result_count, setting_count);
      $display("  %0d enqueues admitted or takes granted, %0d enqueues refused",
               accept_count, refusal_count);
      if (open_count != 0)
         $display("%0d results never arrived", open_count);
      if (fault_count == 0 && open_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/rlt_pkg.sv
src/rlt_step.sv
src/request_lifecycle_tracker.sv
verif/lifecycle_checker.sv
verif/tb_request_lifecycle_tracker.sv
